@@ hw/rtl/fbls_pkg.sv @@
package fbls_pkg;

    // op codes of an input item
    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_FRAME = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_TONE_RELOAD = 2'd0;
    localparam logic [1:0] REG_BLANK_LINES = 2'd1;
    localparam logic [1:0] REG_LINE_REPEAT = 2'd2;

    localparam logic [7:0] RESET_BLANK  = 8'd90;
    localparam logic [3:0] RESET_REPEAT = 4'd6;
    localparam logic [3:0] MAX_REPEAT   = 4'd8;

    typedef struct packed {
        logic [1:0]  op;
        logic [10:0] store_address;
        logic [7:0]  store_data;
    } item_t;

    typedef struct packed {
        logic [1:0]  pixel_first;
        logic [1:0]  pixel_second;
        logic [1:0]  pixel_third;
        logic [1:0]  pixel_fourth;
        logic        pixels_valid;
        logic [7:0]  row_shown;
        logic        audio_level;
        logic [31:0] frame_count;
        logic        last;
    } result_t;

    typedef struct packed {
        logic clear_step;   // zero one store entry, advance clear pointer
        logic store_wr;     // store-write transaction
        logic frame_start;  // frame-start transaction
        logic tick_start;   // line-tick transaction: step tone divider
        logic blank_load;   // load a blank result into the output register
        logic read_first;   // read first byte of the current row
        logic read_next;    // read following byte
        logic pix_load;     // load fetched byte into the output register
        logic row_step;     // line done: advance repeat/row counters
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic blank_line;
        logic out_free;
        logic issue_last;
    } stat_t;

endpackage

@@ hw/rtl/fbls_ctrl.sv @@
module fbls_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  logic [1:0]     op,
    output logic           item_ready,
    input  fbls_pkg::stat_t stat,
    output fbls_pkg::cmd_t  cmd
);
    import fbls_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TICK,
        ST_LINE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_STORE: cmd.store_wr    = 1'b1;
                        OP_FRAME: cmd.frame_start = 1'b1;
                        OP_TICK:
                        begin
                            cmd.tick_start = 1'b1;
                            state_next     = ST_TICK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_TICK:
            begin
                if (stat.blank_line)
                begin
                    if (stat.out_free)
                    begin
                        cmd.blank_load = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.read_first = 1'b1;
                    state_next     = ST_LINE;
                end
            end
            ST_LINE:
            begin
                // fetched byte waits in the read register until output frees up
                if (stat.out_free)
                begin
                    cmd.pix_load = 1'b1;
                    if (stat.issue_last)
                    begin
                        cmd.row_step = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        cmd.read_next = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/fbls_datapath.sv @@
module fbls_datapath #(
    parameter int ROWS          = 60,
    parameter int BYTES_PER_ROW = 30
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fbls_pkg::item_t   item,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  fbls_pkg::cmd_t    cmd,
    output fbls_pkg::stat_t   stat,
    output logic              result_valid,
    input  logic              result_ready,
    output fbls_pkg::result_t result
);
    import fbls_pkg::*;

    localparam int STORE_SIZE = ROWS * BYTES_PER_ROW;
    localparam int STORE_AW   = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int CMP_W      = ((STORE_AW > 11) ? STORE_AW : 11) + 1;
    localparam int BYTE_W     = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;

    logic [7:0]  store_mem [STORE_SIZE];

    logic [7:0]  tone_reload_reg;
    logic [7:0]  blank_lines_reg;
    logic [3:0]  line_repeat_reg;

    logic [STORE_AW-1:0] clr_addr_reg;
    logic [STORE_AW-1:0] rd_ptr_reg;
    logic [BYTE_W-1:0]   byte_idx_reg;
    logic [7:0]          rd_data_reg;

    logic [7:0]  blank_remaining_reg;
    logic [7:0]  row_index_reg;
    logic [2:0]  repeat_done_reg;
    logic [7:0]  tone_counter_reg;
    logic        audio_reg;
    logic [31:0] frames_reg;

    logic        out_valid_reg;
    result_t     out_data_reg;

    logic                store_hit;
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [7:0]          wr_data;
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;
    logic [STORE_AW-1:0] row_base;
    logic [3:0]          rep_eff;
    logic                row_done;

    assign store_hit = CMP_W'(item.store_address) < CMP_W'(STORE_SIZE);
    assign wr_en     = cmd.clear_step || (cmd.store_wr && store_hit);
    assign wr_addr   = cmd.clear_step ? clr_addr_reg : STORE_AW'(item.store_address);
    assign wr_data   = cmd.clear_step ? 8'd0 : item.store_data;

    // row_index < ROWS whenever a row is fetched, so the base stays in range
    assign row_base  = STORE_AW'(32'(row_index_reg) * BYTES_PER_ROW);
    assign rd_en     = cmd.read_first || cmd.read_next;
    assign rd_addr   = cmd.read_first ? row_base : rd_ptr_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_comb
    begin
        if (line_repeat_reg == 4'd0)
        begin
            rep_eff = 4'd1;
        end
        else if (line_repeat_reg > MAX_REPEAT)
        begin
            rep_eff = MAX_REPEAT;
        end
        else
        begin
            rep_eff = line_repeat_reg;
        end
    end

    assign row_done = ({1'b0, repeat_done_reg} + 4'd1) >= rep_eff;

    assign stat.clear_last = (clr_addr_reg == STORE_AW'(STORE_SIZE - 1));
    assign stat.blank_line = (blank_remaining_reg != 8'd0)
                          || ({1'b0, row_index_reg} >= 9'(ROWS));
    assign stat.out_free   = !out_valid_reg || result_ready;
    assign stat.issue_last = (byte_idx_reg == BYTE_W'(BYTES_PER_ROW - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_reload_reg     <= 8'd0;
            blank_lines_reg     <= RESET_BLANK;
            line_repeat_reg     <= RESET_REPEAT;
            clr_addr_reg        <= '0;
            rd_ptr_reg          <= '0;
            byte_idx_reg        <= '0;
            blank_remaining_reg <= 8'd0;
            row_index_reg       <= 8'd0;
            repeat_done_reg     <= 3'd0;
            tone_counter_reg    <= 8'd0;
            audio_reg           <= 1'b0;
            frames_reg          <= 32'd0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TONE_RELOAD: tone_reload_reg <= cfg_data;
                    REG_BLANK_LINES: blank_lines_reg <= cfg_data;
                    REG_LINE_REPEAT: line_repeat_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end

            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end

            if (rd_en)
            begin
                rd_ptr_reg   <= rd_addr;
                byte_idx_reg <= cmd.read_first ? '0 : byte_idx_reg + 1'b1;
            end

            if (cmd.frame_start)
            begin
                row_index_reg       <= 8'd0;
                repeat_done_reg     <= 3'd0;
                blank_remaining_reg <= blank_lines_reg;
                frames_reg          <= frames_reg + 32'd1;
            end

            if (cmd.tick_start && tone_reload_reg != 8'd0)
            begin
                if (tone_counter_reg == 8'd0)
                begin
                    audio_reg        <= !audio_reg;
                    tone_counter_reg <= tone_reload_reg;
                end
                else
                begin
                    tone_counter_reg <= tone_counter_reg - 8'd1;
                end
            end

            if (cmd.blank_load && blank_remaining_reg != 8'd0)
            begin
                blank_remaining_reg <= blank_remaining_reg - 8'd1;
            end

            if (cmd.row_step)
            begin
                if (row_done)
                begin
                    repeat_done_reg <= 3'd0;
                    row_index_reg   <= row_index_reg + 8'd1;
                end
                else
                begin
                    repeat_done_reg <= repeat_done_reg + 3'd1;
                end
            end

            if (cmd.blank_load || cmd.pix_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.blank_load || cmd.pix_load)
        begin
            out_data_reg.pixel_first  <= cmd.pix_load ? rd_data_reg[7:6] : 2'd0;
            out_data_reg.pixel_second <= cmd.pix_load ? rd_data_reg[5:4] : 2'd0;
            out_data_reg.pixel_third  <= cmd.pix_load ? rd_data_reg[3:2] : 2'd0;
            out_data_reg.pixel_fourth <= cmd.pix_load ? rd_data_reg[1:0] : 2'd0;
            out_data_reg.pixels_valid <= cmd.pix_load;
            out_data_reg.row_shown    <= row_index_reg;
            out_data_reg.audio_level  <= audio_reg;
            out_data_reg.frame_count  <= frames_reg;
            out_data_reg.last         <= cmd.blank_load || stat.issue_last;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

@@ hw/rtl/framebuffer_line_scanout_with_tone_top.sv @@
// Line scanout sequencer for a 2-bit-per-pixel frame store with a tone divider.
// Input channel (item_valid/item_ready/item) carries three kinds of transaction:
// store write, frame start and line tick. Stores and frame starts give no result.
// A line tick gives one blank result, or one result per stored byte of the
// current row (four pixels each), with last set on the final one. Output
// channel is result_valid/result_ready/result.
// Timing: a tick goes to ST_TICK, where a blank line loads its result into the
// output register and a visible line reads its first byte into the read
// register; then ST_LINE gives one byte per cycle while the receiver is ready,
// paced by the single read port of the frame store. One item is in work at a
// time; item_ready is low while a line is being emitted.
// Reset: after rst_n releases, the frame store is zeroed one byte per cycle,
// all ROWS * BYTES_PER_ROW bytes (1800 by default); item_ready stays low until
// done. Config writes (cfg_we/cfg_index/cfg_data) are taken at any time.
// Receiver stall: the output register holds its result and the next fetched
// byte waits in the read register; nothing is dropped.
module framebuffer_line_scanout_with_tone_top #(
    parameter int ROWS          = 60,
    parameter int BYTES_PER_ROW = 30
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  fbls_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output fbls_pkg::result_t result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data
);
    import fbls_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    fbls_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .op         (item.op),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    fbls_datapath #(
        .ROWS          (ROWS),
        .BYTES_PER_ROW (BYTES_PER_ROW)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // no transaction accepted while the store is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> !item_ready)
        else $error("item accepted during store clear");

    // output register is only loaded when it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pix_load || cmd.blank_load) |-> stat.out_free)
        else $error("output register overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.pix_load && cmd.blank_load))
        else $error("blank and pixel load together");

    // row counters advance only with the last byte of a line
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.row_step |-> (cmd.pix_load && stat.issue_last))
        else $error("row step without last byte");

endmodule

@@ tb/tb.sv @@
module tb;
    import fbls_pkg::*;

    localparam int ROWS            = 60;
    localparam int BYTES_PER_ROW   = 30;
    localparam int STORE_BYTES     = ROWS * BYTES_PER_ROW;
    localparam int ITEM_TARGET     = 400;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    item_t       item = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_t     result;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    framebuffer_line_scanout_with_tone_top #(
        .ROWS          (ROWS),
        .BYTES_PER_ROW (BYTES_PER_ROW)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // scanout state as the block should hold it
    logic [7:0]  shadow_store [STORE_BYTES];
    logic [7:0]  blank_left  = '0;
    logic [7:0]  cur_row     = '0;
    logic [2:0]  shows_done  = '0;
    logic [7:0]  tone_count  = '0;
    logic        audio       = 1'b0;
    logic [31:0] frames      = '0;
    logic [7:0]  tone_reload_m = 8'd0;
    logic [7:0]  blank_lines_m = RESET_BLANK;
    logic [3:0]  line_repeat_m = RESET_REPEAT;

    item_t   pending_items[$];
    result_t expected_pixels[$];

    int  items_offered   = 0;
    int  line_ticks      = 0;
    int  blank_ticks     = 0;
    int  store_writes    = 0;
    int  frame_starts    = 0;
    int  results_checked = 0;
    int  mismatches      = 0;
    int  cycle_count     = 0;
    int  send_wait       = 0;
    int  ready_wait      = 0;
    bit  no_idle         = 1'b0;
    logic hold_off       = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_count, expected_pixels.size());
        $display("framebuffer_line_scanout_with_tone_top verification failed");
        $finish;
    end

    task automatic scan_predict(input item_t it);
        result_t    r;
        logic [7:0] pix_byte;
        int         shows;
        case (it.op)
            OP_STORE:
            begin
                store_writes++;
                if (it.store_address < STORE_BYTES)
                    shadow_store[it.store_address] = it.store_data;
            end
            OP_FRAME:
            begin
                frame_starts++;
                cur_row    = '0;
                shows_done = '0;
                blank_left = blank_lines_m;
                frames     = frames + 32'd1;
            end
            OP_TICK:
            begin
                line_ticks++;
                if (tone_reload_m != 0)
                begin
                    if (tone_count == 0)
                    begin
                        audio      = ~audio;
                        tone_count = tone_reload_m;
                    end
                    else
                        tone_count = tone_count - 8'd1;
                end
                r = '0;
                r.row_shown   = cur_row;
                r.audio_level = audio;
                r.frame_count = frames;
                if (blank_left != 0 || cur_row >= ROWS)
                begin
                    if (blank_left != 0)
                        blank_left = blank_left - 8'd1;
                    r.last = 1'b1;
                    expected_pixels.push_back(r);
                    blank_ticks++;
                end
                else
                begin
                    r.pixels_valid = 1'b1;
                    for (int k = 0; k < BYTES_PER_ROW; k++)
                    begin
                        pix_byte = shadow_store[cur_row * BYTES_PER_ROW + k];
                        {r.pixel_first, r.pixel_second, r.pixel_third, r.pixel_fourth} = pix_byte;
                        r.last = (k == BYTES_PER_ROW - 1);
                        expected_pixels.push_back(r);
                    end
                    // repeat count is clamped to 1..8
                    shows = int'(line_repeat_m);
                    if (shows == 0)
                        shows = 1;
                    if (shows > int'(MAX_REPEAT))
                        shows = int'(MAX_REPEAT);
                    if (int'(shows_done) + 1 >= shows)
                    begin
                        shows_done = '0;
                        cur_row    = cur_row + 8'd1;
                    end
                    else
                        shows_done = shows_done + 3'd1;
                end
            end
            default: ;
        endcase
    endtask

    function automatic string fmt_result(input result_t r);
        return $sformatf("pix %0d %0d %0d %0d valid %b row %0d audio %b frame %0d last %b",
                         r.pixel_first, r.pixel_second, r.pixel_third, r.pixel_fourth,
                         r.pixels_valid, r.row_shown, r.audio_level, r.frame_count, r.last);
    endfunction

    // driver: one transaction at a time from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (item_valid && item_ready)
                scan_predict(item);
            if (!item_valid || item_ready)
            begin
                if (send_wait != 0)
                begin
                    send_wait--;
                    item_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    item       <= pending_items.pop_front();
                    item_valid <= 1'b1;
                    send_wait = no_idle ? 0 : $urandom_range(0, 9);
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor: check each result transaction against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            ready_wait = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: %s", fmt_result(result));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    results_checked++;
                    if (result.pixel_first  !== want.pixel_first  ||
                        result.pixel_second !== want.pixel_second ||
                        result.pixel_third  !== want.pixel_third  ||
                        result.pixel_fourth !== want.pixel_fourth ||
                        result.pixels_valid !== want.pixels_valid ||
                        result.row_shown    !== want.row_shown    ||
                        result.audio_level  !== want.audio_level  ||
                        result.frame_count  !== want.frame_count  ||
                        result.last         !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch at result %0d", results_checked);
                            $display("  expected %s", fmt_result(want));
                            $display("  actual   %s", fmt_result(result));
                        end
                    end
                end
                ready_wait = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (hold_off)
                result_ready <= 1'b0;
            else if (ready_wait != 0)
            begin
                ready_wait--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // long receiver stall while the sender keeps offering
    initial
    begin
        wait (results_checked >= 600);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    function automatic item_t make_item(input logic [1:0] op, input logic [10:0] addr,
                                        input logic [7:0] data);
        item_t it;
        it.op            = op;
        it.store_address = addr;
        it.store_data    = data;
        return it;
    endfunction

    function automatic item_t random_store();
        logic [10:0] addr;
        if ($urandom_range(0, 9) == 0)
            addr = 11'($urandom_range(STORE_BYTES, 2047));
        else
            addr = 11'($urandom_range(0, STORE_BYTES - 1));
        return make_item(OP_STORE, addr, 8'($urandom_range(0, 255)));
    endfunction

    task automatic offer(input item_t it);
        pending_items.push_back(it);
        if (it.op != OP_UNUSED)
            items_offered++;
    endtask

    task automatic offer_noise();
        case ($urandom_range(0, 2))
            0: offer(make_item(OP_UNUSED, 11'($urandom_range(0, 2047)),
                               8'($urandom_range(0, 255))));
            1: offer(make_item(OP_FRAME, 11'($urandom_range(0, 2047)),
                               8'($urandom_range(0, 255))));
            default: offer(make_item(OP_STORE, 11'($urandom_range(STORE_BYTES, 2047)),
                                     8'($urandom_range(0, 255))));
        endcase
    endtask

    task automatic queue_frame(input int ticks, input bit with_start);
        if (with_start)
            offer(make_item(OP_FRAME, 11'($urandom_range(0, 2047)),
                            8'($urandom_range(0, 255))));
        repeat (ticks)
        begin
            if ($urandom_range(0, 2) == 0)
                offer(random_store());
            offer(make_item(OP_TICK, 11'($urandom_range(0, 2047)),
                            8'($urandom_range(0, 255))));
            if ($urandom_range(0, 24) == 0)
                offer_noise();
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || item_valid || expected_pixels.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_TONE_RELOAD: tone_reload_m = value;
            REG_BLANK_LINES: blank_lines_m = value;
            REG_LINE_REPEAT: line_repeat_m = value[3:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [7:0] tone, input logic [7:0] blank,
                            input logic [7:0] rep);
        write_reg(REG_TONE_RELOAD, tone);
        write_reg(REG_BLANK_LINES, blank);
        write_reg(REG_LINE_REPEAT, rep);
    endtask

    initial
    begin
        logic [7:0] tone;
        logic [7:0] rep;
        for (int i = 0; i < STORE_BYTES; i++)
            shadow_store[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, first frame before any frame start,
        // store edges, ignored writes and op, blank lines after a frame start
        offer(make_item(OP_STORE, 11'd0, 8'hff));
        offer(make_item(OP_STORE, 11'd29, 8'h1b));
        offer(make_item(OP_STORE, 11'd30, 8'he4));
        offer(make_item(OP_STORE, 11'(STORE_BYTES - 1), 8'h00));
        offer(make_item(OP_STORE, 11'(STORE_BYTES), 8'hff));
        offer(make_item(OP_STORE, 11'h7ff, 8'hff));
        repeat (7)
            offer(make_item(OP_TICK, 11'h7ff, 8'hff));
        offer(make_item(OP_UNUSED, 11'h7ff, 8'hff));
        offer(make_item(OP_FRAME, 11'h000, 8'h00));
        repeat (3)
            offer(make_item(OP_TICK, 11'h000, 8'h00));
        wait_idle();

        // no blank lines, one show per row: run past the last row
        set_regs(8'd1, 8'd0, 8'd1);
        queue_frame(66, 1'b1);
        wait_idle();

        set_regs(8'd255, 8'd255, 8'd8);
        no_idle = 1'b1;
        queue_frame(20, 1'b1);
        wait_idle();

        // repeat of zero acts as one, above eight acts as eight
        no_idle = 1'b0;
        set_regs(8'd0, 8'd3, {4'($urandom_range(0, 15)), 4'd0});
        queue_frame(15, 1'b1);
        wait_idle();
        set_regs(8'd2, 8'd1, {4'($urandom_range(0, 15)), 4'd15});
        queue_frame(20, 1'b1);
        wait_idle();

        while (items_offered < ITEM_TARGET)
        begin
            tone = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 4));
            rep  = 8'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(1, 8));
            set_regs(tone, 8'($urandom_range(0, 6)), rep);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (3)
                queue_frame($urandom_range(2, 16), $urandom_range(0, 5) != 0);
            wait_idle();
        end
        repeat (20) @(posedge clk);

        $display("covered %0d line ticks (%0d blank), %0d store writes, %0d frame starts",
                 line_ticks, blank_ticks, store_writes, frame_starts);
        $display("%0d result transactions checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("framebuffer_line_scanout_with_tone_top verification clean");
        else
            $display("framebuffer_line_scanout_with_tone_top verification failed");
        $finish;
    end
endmodule
